// File: rtl/core/osdol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdol_pkg
// Shared widths, register indexes, outline mode codes and helper types for
// the pixel outline dilation core.
// ----------------------------------------------------------------------------
package osdol_pkg;

	localparam int WORD_W             = 32;
	localparam int PIX_PER_WORD       = 16;
	localparam int MODE_W             = 3;
	localparam int LINES_W            = 10;
	localparam int CFG_IDX_W          = 1;
	localparam int CFG_DATA_W         = 10;
	localparam int WORDS_PER_LINE_DEF = 23;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OUTLINE_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LINES  = 1'd1;

	// outline modes
	localparam logic [MODE_W-1:0] MODE_OFF        = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LEFT_BELOW = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FOUR       = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FOUR_FAR   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FOUR_DIAG  = 3'd4;

	localparam logic [LINES_W-1:0] FRAME_LINES_RST = 10'd256;

	// white bits of the neighbors of one pixel
	typedef struct packed {
		logic l2;
		logic l1;
		logic r1;
		logic r2;
		logic u;
		logic ul;
		logic ur;
		logic b;
		logic bl;
		logic br;
	} osdol_nbr_t;

	// words tapped from the line window for the word being emitted
	typedef struct packed {
		logic [WORD_W-1:0] cur;
		logic [WORD_W-1:0] prev;
		logic [WORD_W-1:0] next;
		logic [WORD_W-1:0] up;
	} osdol_taps_t;

	// pick the white bit of each pixel
	function automatic logic [PIX_PER_WORD-1:0] osdol_whites(input logic [WORD_W-1:0] w);
		logic [PIX_PER_WORD-1:0] r;
		for (int k = 0; k < PIX_PER_WORD; k++) begin
			r[k] = w[2*k];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/osdol_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdol_in_if
// Pixel word stream into the outline core: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface osdol_in_if import osdol_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] pixel_word;
	logic              frame_start;

	modport source (output valid, output pixel_word, output frame_start, input ready);
	modport sink   (input valid, input pixel_word, input frame_start, output ready);

endinterface

// File: rtl/core/osdol_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdol_out_if
// Outlined word stream out of the outline core: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface osdol_out_if import osdol_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] outlined_word;
	logic              frame_last;

	modport source (output valid, output outlined_word, output frame_last, input ready);
	modport sink   (input valid, input outlined_word, input frame_last, output ready);

endinterface

// File: rtl/core/osdol_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdol_window
// Two-line shift window. Every advance shifts one word in; fixed taps give
// the word one line back, its horizontal neighbors and the word two lines back.
// ----------------------------------------------------------------------------
module osdol_window import osdol_pkg::*; #(
	parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF
) (
	input  logic              clk,
	input  logic              advance,
	input  logic [WORD_W-1:0] din,
	output osdol_taps_t       taps
);

	localparam int DEPTH = 2 * WORDS_PER_LINE;

	logic [WORD_W-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (advance) begin
			line_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign taps.cur  = line_q[WORDS_PER_LINE-1];
	assign taps.prev = line_q[WORDS_PER_LINE];
	assign taps.next = line_q[WORDS_PER_LINE-2];
	assign taps.up   = line_q[DEPTH-1];

endmodule

// File: rtl/core/osdol_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdol_lane
// One pixel lane: decides from the white neighbors and the outline mode
// whether the pixel's enable bit is set.
// ----------------------------------------------------------------------------
module osdol_lane import osdol_pkg::*; (
	input  logic [MODE_W-1:0] mode,
	input  osdol_nbr_t        nbr,
	output logic              black
);

	logic four;

	assign four = nbr.l1 | nbr.r1 | nbr.u | nbr.b;

	always_comb begin
		case (mode)
			MODE_OFF:        black = 1'b0;
			MODE_LEFT_BELOW: black = nbr.r1 | nbr.b;
			MODE_FOUR:       black = four;
			MODE_FOUR_FAR:   black = four | nbr.l2 | nbr.r2;
			MODE_FOUR_DIAG:  black = four | nbr.ul | nbr.ur | nbr.bl | nbr.br;
			default:         black = 1'b0;
		endcase
	end

endmodule

// File: rtl/core/osd_pixel_outline_dilation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osd_pixel_outline_dilation_core
// Outline dilation of a 2-bit-per-pixel raster, sixteen pixel lanes per word.
// ----------------------------------------------------------------------------
// The core takes one frame word per clock while ready, and returns each word
// one line later, once the line below it has arrived: the beat accepted at
// line L, column c releases word (L-1, c), and line 0 releases nothing. A
// two-line shift window of 2*WORDS_PER_LINE words holds the neighborhood,
// and sixteen pixel lanes compute the enable bits of a word in the same
// cycle, so the sustained rate is one word per clock while the output queue
// has room. When the last word of the frame is taken, the input stalls
// while the window shifts the held last line out, the final beat marked
// with frame_last; after a frame_start the held words are dropped. Results
// pass through a two-entry output queue, so a stalled result does not hold
// the input back at once. Configuration writes belong in idle time only.
// ----------------------------------------------------------------------------
module osd_pixel_outline_dilation_core import osdol_pkg::*; #(
	parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	osdol_in_if.sink              pixels,
	osdol_out_if.source           outline,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(WORDS_PER_LINE - 1);

	logic [MODE_W-1:0]  mode_q;
	logic [LINES_W-1:0] frame_lines_q;
	logic [COL_W-1:0]   col_q;
	logic [LINES_W-1:0] line_q;
	logic               flush_q;
	logic               flush_up_q;

	logic [WORD_W-1:0]  fifo_word_q [2];
	logic               fifo_last_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         fifo_cnt_q;

	logic               fifo_full;
	logic               in_acc;
	logic               flush_step;
	logic               advance;
	logic               restart;
	logic [COL_W-1:0]   col_eff;
	logic [LINES_W-1:0] line_eff;
	logic [LINES_W-1:0] last_line;
	logic               col_last;
	logic               end_frame;
	logic               push;
	logic               pop;
	logic               has_up;
	logic               has_below;
	osdol_taps_t        taps;

	logic [PIX_PER_WORD-1:0]   cur_wh;
	logic [PIX_PER_WORD-1:0]   prev_wh;
	logic [PIX_PER_WORD-1:0]   next_wh;
	logic [PIX_PER_WORD-1:0]   up_wh;
	logic [PIX_PER_WORD-1:0]   bel_wh;
	logic [PIX_PER_WORD+3:0]   hrow;
	logic [PIX_PER_WORD+1:0]   upad;
	logic [PIX_PER_WORD+1:0]   bpad;
	logic [PIX_PER_WORD-1:0]   black;
	logic [WORD_W-1:0]         black_mask;
	logic [WORD_W-1:0]         res_word;
	logic                      res_last;

	// handshake and sequencing
	assign fifo_full    = (fifo_cnt_q == 2'd2);
	assign pixels.ready = !flush_q && !fifo_full;
	assign in_acc       = pixels.valid && pixels.ready;
	assign flush_step   = flush_q && !fifo_full;
	assign advance      = in_acc || flush_step;
	assign restart      = in_acc && pixels.frame_start;

	assign col_eff   = restart ? '0 : col_q;
	assign line_eff  = restart ? '0 : line_q;
	assign last_line = frame_lines_q - LINES_W'(1);
	assign col_last  = (col_eff == COL_LAST);
	assign end_frame = in_acc && (line_eff == last_line) && col_last;

	assign push = (in_acc && (line_eff != '0)) || flush_step;
	assign pop  = outline.valid && outline.ready;

	assign has_up    = flush_q ? flush_up_q : (line_eff != LINES_W'(1));
	assign has_below = !flush_q;

	osdol_window #(
		.WORDS_PER_LINE (WORDS_PER_LINE)
	) u_window (
		.clk     (clk),
		.advance (advance),
		.din     (pixels.pixel_word),
		.taps    (taps)
	);

	// neighborhood rows; drop horizontal neighbors past the line ends
	assign cur_wh  = osdol_whites(taps.cur);
	assign prev_wh = (col_eff != '0) ? osdol_whites(taps.prev) : '0;
	assign next_wh = !col_last ? osdol_whites(taps.next) : '0;
	assign up_wh   = has_up ? osdol_whites(taps.up) : '0;
	assign bel_wh  = has_below ? osdol_whites(pixels.pixel_word) : '0;

	assign hrow = {next_wh[1:0], cur_wh, prev_wh[PIX_PER_WORD-1:PIX_PER_WORD-2]};
	assign upad = {1'b0, up_wh, 1'b0};
	assign bpad = {1'b0, bel_wh, 1'b0};

	for (genvar p = 0; p < PIX_PER_WORD; p++) begin : g_lane
		osdol_nbr_t nbr;

		assign nbr.l2 = hrow[p];
		assign nbr.l1 = hrow[p+1];
		assign nbr.r1 = hrow[p+3];
		assign nbr.r2 = hrow[p+4];
		assign nbr.u  = up_wh[p];
		assign nbr.ul = upad[p];
		assign nbr.ur = upad[p+2];
		assign nbr.b  = bel_wh[p];
		assign nbr.bl = bpad[p];
		assign nbr.br = bpad[p+2];

		osdol_lane u_lane (
			.mode  (mode_q),
			.nbr   (nbr),
			.black (black[p])
		);

		assign black_mask[2*p]   = 1'b0;
		assign black_mask[2*p+1] = black[p];
	end

	// merge lane results into the word
	assign res_word = taps.cur | black_mask;
	assign res_last = flush_q && col_last;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_FOUR;
			frame_lines_q <= FRAME_LINES_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_OUTLINE_MODE: mode_q        <= cfg_data[MODE_W-1:0];
				REG_FRAME_LINES:  frame_lines_q <= cfg_data[LINES_W-1:0];
				default: ;
			endcase
		end
	end

	// position counters and end-of-frame flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			line_q     <= '0;
			flush_q    <= 1'b0;
			flush_up_q <= 1'b0;
		end else if (in_acc) begin
			if (end_frame) begin
				col_q      <= '0;
				line_q     <= '0;
				flush_q    <= 1'b1;
				flush_up_q <= (line_eff != '0);
			end else if (col_last) begin
				col_q  <= '0;
				line_q <= line_eff + LINES_W'(1);
			end else begin
				col_q  <= col_eff + COL_W'(1);
				line_q <= line_eff;
			end
		end else if (flush_step) begin
			if (col_last) begin
				flush_q <= 1'b0;
				col_q   <= '0;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// output queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= 1'b0;
			rd_ptr_q   <= 1'b0;
			fifo_cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fifo_cnt_q <= fifo_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_word_q[wr_ptr_q] <= res_word;
			fifo_last_q[wr_ptr_q] <= res_last;
		end
	end

	assign outline.valid         = (fifo_cnt_q != 2'd0);
	assign outline.outlined_word = fifo_word_q[rd_ptr_q];
	assign outline.frame_last    = fifo_last_q[rd_ptr_q];

endmodule

// File: rtl/core/osdol_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdol_checker
// Port-level checks on the outline core, attached by bind.
// ----------------------------------------------------------------------------
module osdol_checker import osdol_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] out_word,
	input logic              out_last
);

	// nothing to deliver right after reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result shown right after reset");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
		else $error("stalled result changed");

	// no two frame_last beats are accepted in a row
	a_last_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !(out_valid && out_ready && out_last))
		else $error("two frame_last beats in a row");

	// input held off with an empty queue means a flush beat is on its way
	a_flush_progress: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !out_valid |=> out_valid)
		else $error("input stalled without pending flush result");

endmodule

bind osd_pixel_outline_dilation_core osdol_checker u_osdol_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pixels.ready),
	.out_valid (outline.valid),
	.out_ready (outline.ready),
	.out_word  (outline.outlined_word),
	.out_last  (outline.frame_last)
);
